FILE: rtl/core/swkth_pkg.sv
package swkth_pkg;

   // Window geometry
   localparam int WINDOW = 64;
   localparam int IDX_W  = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int DATA_W = 32;

   // Reset value of the window size register
   localparam logic [CNT_W-1:0] WSIZE_RESET = CNT_W'(WINDOW);

   // Broadcast to every cell for one update
   typedef struct packed {
      logic                     en;      // an item is accepted this cycle
      logic signed [DATA_W-1:0] sample;  // new sample to insert
      logic [IDX_W-1:0]         slot;    // arrival slot of the new sample
      logic                     del_en;  // window full: drop the oldest entry
   } upd_type;

   // What a cell shows its neighbors
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         slot;
      logic                     gt;      // entry sorts after the new sample
   } link_type;

endpackage

FILE: rtl/core/sliding_window_kth_smallest_top.sv
// Sliding-window k-th smallest (rank-order) filter.
// req channel: each transfer carries a signed 32-bit sample and a rank k.
// The newest window_size samples are kept in a row of 64 cells in sorted
// order; once the window is full, each accepted sample drops the oldest entry
// and is inserted in the same cycle, with every cell choosing its new entry
// from itself, its two neighbors or the sample.
// rsp channel: once the window is full, every sample gives one transfer with
// the k-th smallest value (k = 1 is the minimum). A rank of 0 or above the
// window size gives value 0 with the error flag set in rsp_tuser. Samples
// that arrive while the window fills give no transfer.
// csr channel: writes window_size (0 acts as 1, above 64 acts as 64) and
// empties the window. Write only while no item is in flight.
// The edge that accepts a sample updates the cells and loads the select stage;
// the select stage loads the output register once that register is free.
// Throughput: one sample per cycle while the receiver keeps up, no csr pending.
// Reset: window empty, window_size 64, no result pending.
// When the receiver stalls, one result waits in the output register and one
// in the select stage; req_tready then drops until rsp_tready returns.
module sliding_window_kth_smallest_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] sample, [38:32] rank, [39] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] kth_value
   output logic [0:0]  rsp_tuser,   // [0] rank_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // [6:0] window_size
);
   import swkth_pkg::*;

   logic [CNT_W-1:0]         wsize_ff, wsize_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [IDX_W-1:0]         oldest_ff, oldest_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_idx_ff, pend_idx_in;
   logic                     pend_err_ff, pend_err_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_err_ff, rsp_err_in;

   logic [CNT_W-1:0]         weff;
   logic                     full, emit, accept, pend_move;
   logic [CNT_W-1:0]         rank, rank_m1, oldest_nx;
   logic                     rank_bad;
   upd_type                  upd;
   logic signed [DATA_W-1:0] values [WINDOW];

   // Effective window size
   always_comb begin
      if (wsize_ff == '0) begin
         weff = CNT_W'(1);
      end else if (wsize_ff > CNT_W'(WINDOW)) begin
         weff = CNT_W'(WINDOW);
      end else begin
         weff = wsize_ff;
      end
   end

   // Handshakes
   assign csr_ready  = 1'b1;
   assign pend_move  = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (!pend_ff || pend_move) && !csr_valid;
   assign accept     = req_tvalid && req_tready;

   assign full      = (fill_ff >= weff);
   assign rank      = req_tdata[38:32];
   assign rank_m1   = rank - CNT_W'(1);
   assign rank_bad  = (rank == '0) || (rank > weff);
   assign emit      = full || ((fill_ff + CNT_W'(1)) == weff);
   assign oldest_nx = {1'b0, oldest_ff} + CNT_W'(1);

   // Cell update broadcast
   always_comb begin
      upd.en     = accept;
      upd.sample = req_tdata[31:0];
      upd.slot   = full ? oldest_ff : fill_ff[IDX_W-1:0];
      upd.del_en = full;
   end

   swkth_chain u_chain (
      .clock      (clock),
      .upd        (upd),
      .fill_count (fill_ff),
      .values     (values)
   );

   // Window bookkeeping and configuration
   always_comb begin
      wsize_in  = wsize_ff;
      fill_in   = fill_ff;
      oldest_in = oldest_ff;
      if (csr_valid && csr_ready) begin
         wsize_in  = csr_data;
         fill_in   = '0;
         oldest_in = '0;
      end else if (accept) begin
         if (!full) begin
            fill_in   = fill_ff + CNT_W'(1);
            oldest_in = '0;
         end else if (oldest_nx >= weff) begin
            oldest_in = '0;
         end else begin
            oldest_in = oldest_nx[IDX_W-1:0];
         end
      end
   end

   // Select stage: rank captured with the sample, read after the update
   always_comb begin
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      pend_err_in = pend_err_ff;
      if (pend_move) begin
         pend_in = 1'b0;
      end
      if (accept && emit) begin
         pend_in     = 1'b1;
         pend_idx_in = rank_m1[IDX_W-1:0];
         pend_err_in = rank_bad;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_err_ff ? '0 : values[pend_idx_ff];
         rsp_err_in   = pend_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff     <= WSIZE_RESET;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wsize_ff     <= wsize_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      pend_err_ff <= pend_err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

FILE: rtl/core/swkth_cell.sv
module swkth_cell (
   input  logic                        clock,
   input  swkth_pkg::upd_type          upd,
   input  logic                        valid,      // entry holds a live sample
   input  swkth_pkg::link_type         lo_link,    // neighbor one place lower
   input  swkth_pkg::link_type         hi_link,    // neighbor one place higher
   input  logic                        del_below,  // deleted entry sits lower
   output logic                        del_above,  // deleted entry at or below here
   output swkth_pkg::link_type         link
);
   import swkth_pkg::*;

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic                     del_here;

   // Local view: does this entry sort after the sample, is it the oldest
   always_comb begin
      link.value = value_ff;
      link.slot  = slot_ff;
      link.gt    = !valid || (value_ff > upd.sample);
      del_here   = valid && upd.del_en && (slot_ff == upd.slot);
      del_above  = del_below || del_here;
   end

   // Pick the entry that lands here: own, from above, from below, or the sample
   always_comb begin
      value_in = value_ff;
      slot_in  = slot_ff;
      if ((!del_below && !del_here && !link.gt) || (del_below && link.gt)) begin
         value_in = value_ff;
         slot_in  = slot_ff;
      end else if (del_above && !hi_link.gt) begin
         value_in = hi_link.value;
         slot_in  = hi_link.slot;
      end else if (!del_below && lo_link.gt) begin
         value_in = lo_link.value;
         slot_in  = lo_link.slot;
      end else begin
         value_in = upd.sample;
         slot_in  = upd.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.en) begin
         value_ff <= value_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

FILE: rtl/core/swkth_chain.sv
module swkth_chain (
   input  logic                                       clock,
   input  swkth_pkg::upd_type                         upd,
   input  logic [swkth_pkg::CNT_W-1:0]                fill_count,
   output logic signed [swkth_pkg::DATA_W-1:0]        values [swkth_pkg::WINDOW]
);
   import swkth_pkg::*;

   link_type links [WINDOW];
   logic     dchain [WINDOW+1];
   link_type lo_edge, hi_edge;

   // Ends of the row: nothing moves in from below, nothing drops in from above
   always_comb begin
      lo_edge.value = '0;
      lo_edge.slot  = '0;
      lo_edge.gt    = 1'b0;
      hi_edge.value = '0;
      hi_edge.slot  = '0;
      hi_edge.gt    = 1'b1;
   end

   assign dchain[0] = 1'b0;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      link_type lo_n, hi_n;
      logic     live;

      assign live = (CNT_W'(i) < fill_count);

      if (i == 0) begin : g_lo_end
         assign lo_n = lo_edge;
      end else begin : g_lo_mid
         assign lo_n = links[i-1];
      end

      if (i == WINDOW - 1) begin : g_hi_end
         assign hi_n = hi_edge;
      end else begin : g_hi_mid
         assign hi_n = links[i+1];
      end

      swkth_cell u_cell (
         .clock     (clock),
         .upd       (upd),
         .valid     (live),
         .lo_link   (lo_n),
         .hi_link   (hi_n),
         .del_below (dchain[i]),
         .del_above (dchain[i+1]),
         .link      (links[i])
      );

      assign values[i] = links[i].value;
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

// Running model of the rank filter: window contents in arrival order plus a
// sorted copy, and the queue of results the block still owes.
class kth_scoreboard;
   typedef struct {
      logic signed [swkth_pkg::DATA_W-1:0] value;
      logic                                rank_err;
   } kth_result_type;

   logic signed [swkth_pkg::DATA_W-1:0] arrival [swkth_pkg::WINDOW];
   logic signed [swkth_pkg::DATA_W-1:0] ordered [swkth_pkg::WINDOW];
   int unsigned    fill;
   int unsigned    oldest;
   logic [6:0]     wsize;
   kth_result_type owed [$];
   int             mismatches;

   function new();
      fill       = 0;
      oldest     = 0;
      wsize      = swkth_pkg::WSIZE_RESET;
      mismatches = 0;
   endfunction

   // A window size write also empties the window
   function void set_window(logic [6:0] v);
      wsize  = v;
      fill   = 0;
      oldest = 0;
   endfunction

   // 0 acts as 1, anything above the cell count acts as the cell count
   function int unsigned active_size();
      if (wsize == 0) return 1;
      if (wsize > swkth_pkg::WINDOW) return swkth_pkg::WINDOW;
      return wsize;
   endfunction

   function void ordered_insert(logic signed [swkth_pkg::DATA_W-1:0] v, int unsigned n);
      int unsigned i;
      i = n;
      while (i > 0 && ordered[i-1] > v) begin
         ordered[i] = ordered[i-1];
         i--;
      end
      ordered[i] = v;
   endfunction

   // Drop one entry equal to v; duplicates stay separate
   function void ordered_remove(logic signed [swkth_pkg::DATA_W-1:0] v, int unsigned n);
      int unsigned p;
      p = 0;
      while (p < n && ordered[p] != v) p++;
      if (p >= n) return;
      while (p + 1 < n) begin
         ordered[p] = ordered[p+1];
         p++;
      end
   endfunction

   function void note_sample(logic signed [swkth_pkg::DATA_W-1:0] s, logic [6:0] k);
      int unsigned w;
      int unsigned op;
      logic signed [swkth_pkg::DATA_W-1:0] old;
      kth_result_type r;
      w = active_size();
      if (fill < w) begin
         arrival[fill] = s;
         ordered_insert(s, fill);
         fill++;
         oldest = 0;
      end else begin
         op = oldest;
         if (op >= w) op = 0;
         old = arrival[op];
         arrival[op] = s;
         ordered_remove(old, w);
         ordered_insert(s, w - 1);
         op++;
         if (op >= w) op = 0;
         oldest = op;
      end
      // still filling: no transfer owed
      if (fill < w) return;
      if (k == 0 || k > w) begin
         r.value    = '0;
         r.rank_err = 1'b1;
      end else begin
         r.value    = ordered[k-1];
         r.rank_err = 1'b0;
      end
      owed.push_back(r);
   endfunction

   function void check_result(logic [swkth_pkg::DATA_W-1:0] value, logic rank_err);
      kth_result_type r;
      if (owed.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tb: unexpected result value %0d err %0b", $signed(value), rank_err);
         return;
      end
      r = owed.pop_front();
      if (value !== r.value || rank_err !== r.rank_err) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tb: mismatch: expected value %0d err %0b, got value %0d err %0b",
                     r.value, r.rank_err, $signed(value), rank_err);
      end
   endfunction

   function int pending();
      return owed.size();
   endfunction
endclass

module tb;
   localparam int LIMIT  = 200000;  // cycles before the run is declared hung
   localparam int SETTLE = 6;       // cycles covering the two-stage pipeline

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;

   kth_scoreboard sb;
   int src_idle_pct = 0;
   int snk_stall_pct = 0;
   int cycles = 0;

   sliding_window_kth_smallest_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hang guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Result side backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= snk_stall_pct);
   end

   // Watch every transfer; results first, since one landing now is always
   // owed by an earlier sample
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser[0]);
         if (csr_valid && csr_ready) sb.set_window(csr_data);
         if (req_tvalid && req_tready) sb.note_sample(req_tdata[31:0], req_tdata[38:32]);
      end
   end

   task set_idling(input int mode);
      case (mode)
         0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
         1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
         2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
         default: begin src_idle_pct = 6; snk_stall_pct = 6; end
      endcase
   endtask

   task send_item(input logic [31:0] sample, input logic [6:0] rank);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, rank, sample};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and let every owed result and any filling sample drain
   task wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_window(input logic [6:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mix of extremes, tight clusters for duplicates and full-range values
   function logic [31:0] pick_sample();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3, 4: return 32'($signed($urandom_range(8)) - 4);
         5: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                     : 32'h7FFF_FFFF - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   function logic [6:0] pick_rank(input int unsigned w);
      case ($urandom_range(9))
         0: return 7'd0;
         1: return 7'($urandom_range(64));
         2: return 7'd64;
         default: return 7'($urandom_range(w, 1));
      endcase
   endfunction

   initial begin
      logic [6:0]  sizes [16];
      int unsigned w;
      sizes = '{7'd2, 7'd127, 7'd5, 7'd1, 7'd64, 7'd3, 7'd17, 7'd0,
                7'd8, 7'd4, 7'd33, 7'd7, 7'd2, 7'd6, 7'd64, 7'd3};
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);

      // Reset window of 64: fill with extremes and small values, then query
      for (int i = 0; i < 63; i++) begin
         case (i % 3)
            0: send_item(32'h8000_0000, 7'd64);
            1: send_item(32'h7FFF_FFFF, 7'd0);
            default: send_item(32'(i - 30), 7'd1);
         endcase
      end
      send_item(32'd0, 7'd1);
      send_item(32'hFFFF_FFFF, 7'd64);
      send_item(32'h7FFF_FFFF, 7'd0);
      send_item(32'h8000_0000, 7'd32);
      send_item(32'd1, 7'd33);

      // Window of 3: duplicates, out-of-range ranks, extremes
      write_window(7'd3);
      send_item(32'd5, 7'd1);
      send_item(32'd5, 7'd2);
      send_item(32'd5, 7'd3);
      send_item(32'hFFFF_FFFF, 7'd0);
      send_item(32'h8000_0000, 7'd4);
      send_item(32'h7FFF_FFFF, 7'd3);
      send_item(32'd5, 7'd2);
      send_item(32'd5, 7'd1);
      send_item(32'h8000_0000, 7'd1);
      send_item(32'd0, 7'd64);

      // Window of 1, then 0 which behaves as 1
      write_window(7'd1);
      send_item(32'd7, 7'd1);
      send_item(32'hFFFF_FFF9, 7'd0);
      send_item(32'h7FFF_FFFF, 7'd1);
      send_item(32'h8000_0000, 7'd2);
      write_window(7'd0);
      send_item(32'd3, 7'd1);
      send_item(32'd4, 7'd2);
      send_item(32'hFFFF_FFFF, 7'd1);

      // Random phases over a spread of window sizes and idling patterns
      for (int p = 0; p < 16; p++) begin
         write_window(sizes[p]);
         w = sb.active_size();
         set_idling(p % 4);
         for (int i = 0; i < int'(w) + 36; i++) send_item(pick_sample(), pick_rank(w));
      end

      wait_idle();
      repeat (SETTLE) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
